// File: rtl/core/adaptive_pulse_beat_detector_core_macros.svh
// Assertion macros for the pulse beat detector.
// They expand to nothing when SYNTHESIS is defined.
`ifndef ADAPTIVE_PULSE_BEAT_DETECTOR_CORE_MACROS_SVH
`define ADAPTIVE_PULSE_BEAT_DETECTOR_CORE_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define APBD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("apbd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define APBD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("apbd assertion failed");

`else

`define APBD_ASSERT_IMPL(label, ante, cons)
`define APBD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: rtl/core/apbd_pkg.sv
package apbd_pkg;

  localparam int WEIGHT_W    = 16;
  localparam int FLOOR_W     = 12;
  localparam int DUR_W       = 24;
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_INDEX_W = 3;
  localparam int BPM_W       = 10;

  localparam logic [BPM_W-1:0] BPM_MAX = {BPM_W{1'b1}};

  // 60000000 microseconds per minute, and the largest interval whose
  // rate still exceeds the saturation value.
  localparam int                    RATE_NUM_W     = 26;
  localparam logic [RATE_NUM_W-1:0] RATE_NUMER     = 26'd60000000;
  localparam logic [RATE_NUM_W-1:0] RATE_SAT_LIMIT = 26'd58593;

  localparam logic [WEIGHT_W-1:0] BASELINE_ALPHA_RESET  = 16'd655;
  localparam logic [WEIGHT_W-1:0] SMOOTHING_ALPHA_RESET = 16'd19661;
  localparam logic [WEIGHT_W-1:0] ENVELOPE_DECAY_RESET  = 16'd62915;
  localparam logic [WEIGHT_W-1:0] THRESHOLD_FRAC_RESET  = 16'd32768;
  localparam logic [FLOOR_W-1:0]  AMP_FLOOR_RESET       = 12'd25;
  localparam logic [DUR_W-1:0]    REFRACTORY_RESET      = 24'd300000;
  localparam logic [DUR_W-1:0]    FLASH_RESET           = 24'd60000;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  localparam cfg_index_t REG_BASELINE_ALPHA  = 3'd0;
  localparam cfg_index_t REG_SMOOTHING_ALPHA = 3'd1;
  localparam cfg_index_t REG_ENVELOPE_DECAY  = 3'd2;
  localparam cfg_index_t REG_THRESHOLD_FRAC  = 3'd3;
  localparam cfg_index_t REG_AMP_FLOOR       = 3'd4;
  localparam cfg_index_t REG_REFRACTORY      = 3'd5;
  localparam cfg_index_t REG_FLASH           = 3'd6;
  localparam cfg_index_t REG_INVERT          = 3'd7;

endpackage

// File: rtl/core/adaptive_pulse_beat_detector_core.sv
// Channel   Direction  Payload (lowest bit first)
// s_*       in         sample_value, sample_time
// m_*       out        indicator_on, beat_detected, first_beat, beats_per_minute,
//                      smoothed_signal, beat_threshold
// cfg_*     in         register write, index and data
//
// A result is registered after its sample has passed the base, smoothing, threshold,
// envelope and decide states, and also a 10-step restoring divider when a beat needs
// a rate. The next sample is accepted only once the result is in the output register.
// All products go through one shared multiplier in four passes.
// s_tready is high only while the sequencer is idle; one result register holds
// the output, and a finished sample waits only when that register is still full.
// Reset is synchronous; it restores the register defaults and the detector state.
`include "adaptive_pulse_beat_detector_core_macros.svh"

module adaptive_pulse_beat_detector_core #(
  parameter int SAMPLE_BITS   = 12,
  parameter int FRACTION_BITS = 16,
  parameter int TIME_BITS     = 48
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     s_tvalid,
  output logic                                     s_tready,
  // sample_value, sample_time, zero padding
  input  logic [((SAMPLE_BITS+TIME_BITS+7)/8)*8-1:0] s_tdata,
  output logic                                     m_tvalid,
  input  logic                                     m_tready,
  // indicator_on, beat_detected, first_beat, beats_per_minute, smoothed_signal,
  // beat_threshold, zero padding
  output logic [((2*SAMPLE_BITS+14+7)/8)*8-1:0]      m_tdata,
  input  logic                                     cfg_we,
  input  logic [apbd_pkg::CFG_INDEX_W-1:0]          cfg_index,
  input  logic [apbd_pkg::CFG_DATA_W-1:0]           cfg_data
);
  import apbd_pkg::*;

  localparam int S       = SAMPLE_BITS;
  localparam int F       = FRACTION_BITS;
  localparam int T       = TIME_BITS;
  localparam int OUT_W   = ((2*S+14+7)/8)*8;
  localparam int LEVEL_W = S + F;
  localparam int DIFF_W  = LEVEL_W + 2;
  localparam int PROD_W  = DIFF_W + WEIGHT_W + 1;
  localparam int ACC_W   = PROD_W + 1;
  localparam int THR_W   = S + WEIGHT_W;
  localparam int FLX_W   = LEVEL_W + FLOOR_W;
  localparam int DIVR_W  = RATE_NUM_W + BPM_W - 1;
  localparam int CNT_W   = $clog2(BPM_W);

  localparam logic signed [ACC_W-1:0] LVL_MAX_A =
    {{(ACC_W-LEVEL_W){1'b0}}, {LEVEL_W{1'b1}}};
  localparam logic signed [ACC_W-1:0] LVL_MIN_A =
    {{(ACC_W-LEVEL_W){1'b1}}, {LEVEL_W{1'b0}}};
  localparam logic signed [LEVEL_W+1:0] F_ROUND =
    {{(LEVEL_W+2-F){1'b0}}, {F{1'b1}}};
  localparam logic [T-1:0]     TIME_MAX = {T{1'b1}};
  localparam logic [FLX_W-1:0] SAMPLE_MASK_X = {{(FLX_W-S){1'b0}}, {S{1'b1}}};
  localparam logic [THR_W-1:0] SAMPLE_MAX_X = {{(THR_W-S){1'b0}}, {S{1'b1}}};
  localparam logic [LEVEL_W-1:0] ENV_RESET = LEVEL_W'(AMP_FLOOR_RESET) << F;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_BASE_MUL = 4'd1;
  localparam logic [3:0] ST_BASE_UPD = 4'd2;
  localparam logic [3:0] ST_SMO_MUL  = 4'd3;
  localparam logic [3:0] ST_SMO_UPD  = 4'd4;
  localparam logic [3:0] ST_THR_MUL  = 4'd5;
  localparam logic [3:0] ST_ENV_MUL  = 4'd6;
  localparam logic [3:0] ST_DECIDE   = 4'd7;
  localparam logic [3:0] ST_DIV      = 4'd8;
  localparam logic [3:0] ST_DONE     = 4'd9;

  logic [3:0] state;

  logic [WEIGHT_W-1:0] baseline_alpha;
  logic [WEIGHT_W-1:0] smoothing_alpha;
  logic [WEIGHT_W-1:0] envelope_decay;
  logic [WEIGHT_W-1:0] threshold_fraction;
  logic [FLOOR_W-1:0]  amplitude_floor;
  logic [DUR_W-1:0]    refractory_time;
  logic [DUR_W-1:0]    flash_time;
  logic                invert_polarity;

  logic [LEVEL_W-1:0]        baseline_level;
  logic                      seeded_flag;
  logic signed [LEVEL_W:0]   smoothed_level;
  logic [LEVEL_W-1:0]        peak_envelope;
  logic                      previously_above;
  logic [T-1:0]              last_beat_time;
  logic                      beat_seen;
  logic [T-1:0]              indicator_off_time;

  logic [S-1:0]              raw;
  logic [T-1:0]              now;
  logic signed [PROD_W-1:0]  prod;
  logic [THR_W-1:0]          thr;
  logic                      beat;
  logic                      first;
  logic [BPM_W-1:0]          bpm;
  logic [RATE_NUM_W-1:0]     rem;
  logic [DIVR_W-1:0]         divr;
  logic [CNT_W-1:0]          div_cnt;

  logic [S-1:0]              in_raw;
  logic [T-1:0]              in_time;
  logic [LEVEL_W-1:0]        raw_fx;
  logic [LEVEL_W-1:0]        in_raw_fx;
  logic [FLX_W-1:0]          floor_x;
  logic [LEVEL_W-1:0]        floor_fx;
  logic signed [DIFF_W-1:0]  diff_base;
  logic signed [LEVEL_W:0]   ac;
  logic signed [LEVEL_W:0]   ac_pol;
  logic signed [DIFF_W-1:0]  diff_smo;
  logic [WEIGHT_W-1:0]       mul_w;
  logic signed [DIFF_W-1:0]  mul_d;
  logic signed [PROD_W-1:0]  mul_prod;
  logic signed [PROD_W-1:0]  prod_shift;
  logic signed [ACC_W-1:0]   step_a;
  logic signed [ACC_W-1:0]   acc_base;
  logic signed [ACC_W-1:0]   acc_smo;
  logic signed [ACC_W-1:0]   smoothed_a;
  logic signed [ACC_W-1:0]   thr_a;
  logic signed [ACC_W-1:0]   floor_a;
  logic signed [ACC_W-1:0]   env_max;
  logic signed [ACC_W-1:0]   env_cand;
  logic [LEVEL_W-1:0]        base_new;
  logic signed [LEVEL_W:0]   smo_new;
  logic [LEVEL_W-1:0]        env_new;
  logic                      above;
  logic [T-1:0]              interval;
  logic                      beat_now;
  logic [T-1:0]              off_time;
  logic                      div_ge;
  logic signed [LEVEL_W+1:0] sm_adj;
  logic signed [LEVEL_W+1:0] sm_whole;
  logic [THR_W-1:0]          thr_whole;
  logic [S-1:0]              thr_out;
  logic                      ind_on;
  logic [OUT_W-1:0]          out_word;

  assign in_raw    = s_tdata[S-1:0];
  assign in_time   = s_tdata[S+T-1:S];
  assign raw_fx    = {raw, {F{1'b0}}};
  assign in_raw_fx = {in_raw, {F{1'b0}}};
  assign floor_x   = (FLX_W'(amplitude_floor) & SAMPLE_MASK_X) << F;
  assign floor_fx  = floor_x[LEVEL_W-1:0];

  assign diff_base = $signed({2'b00, raw_fx}) - $signed({2'b00, baseline_level});
  assign ac        = $signed({1'b0, raw_fx}) - $signed({1'b0, baseline_level});
  assign ac_pol    = invert_polarity ? -ac : ac;
  assign diff_smo  = DIFF_W'(ac_pol) - DIFF_W'(smoothed_level);

  always_comb begin
    unique case (state)
      ST_BASE_MUL: begin
        mul_w = baseline_alpha;
        mul_d = diff_base;
      end
      ST_SMO_MUL: begin
        mul_w = smoothing_alpha;
        mul_d = diff_smo;
      end
      ST_THR_MUL: begin
        mul_w = threshold_fraction;
        mul_d = $signed({2'b00, peak_envelope});
      end
      default: begin
        mul_w = envelope_decay;
        mul_d = $signed({2'b00, peak_envelope});
      end
    endcase
  end

  assign mul_prod   = $signed({1'b0, mul_w}) * mul_d;
  assign prod_shift = prod >>> F;
  assign step_a     = ACC_W'(prod_shift);
  assign smoothed_a = ACC_W'(smoothed_level);
  assign acc_base   = $signed({{(ACC_W-LEVEL_W){1'b0}}, baseline_level}) + step_a;
  assign acc_smo    = smoothed_a + step_a;
  assign thr_a      = $signed({{(ACC_W-THR_W){1'b0}}, thr});
  assign floor_a    = $signed({{(ACC_W-LEVEL_W){1'b0}}, floor_fx});

  always_comb begin
    priority if (acc_base < 0) begin
      base_new = '0;
    end else if (acc_base > LVL_MAX_A) begin
      base_new = LVL_MAX_A[LEVEL_W-1:0];
    end else begin
      base_new = acc_base[LEVEL_W-1:0];
    end

    priority if (acc_smo < LVL_MIN_A) begin
      smo_new = LVL_MIN_A[LEVEL_W:0];
    end else if (acc_smo > LVL_MAX_A) begin
      smo_new = LVL_MAX_A[LEVEL_W:0];
    end else begin
      smo_new = acc_smo[LEVEL_W:0];
    end

    env_max  = (smoothed_a > step_a) ? smoothed_a : step_a;
    env_cand = (env_max < floor_a) ? floor_a : env_max;
    env_new  = (env_cand > LVL_MAX_A) ? LVL_MAX_A[LEVEL_W-1:0] : env_cand[LEVEL_W-1:0];
  end

  assign above    = (smoothed_a > thr_a) && (smoothed_a > floor_a);
  assign interval = now - last_beat_time;
  assign beat_now = above && !previously_above && (now > last_beat_time) &&
                    (interval > T'(refractory_time));
  assign off_time = ((TIME_MAX - now) < T'(flash_time)) ? TIME_MAX : now + T'(flash_time);

  assign div_ge = DIVR_W'(rem) >= divr;

  assign sm_adj    = LEVEL_W'(0) + $signed({smoothed_level[LEVEL_W], smoothed_level}) +
                     (smoothed_level[LEVEL_W] ? F_ROUND : '0);
  assign sm_whole  = sm_adj >>> F;
  assign thr_whole = thr >> F;
  assign thr_out   = (thr_whole > SAMPLE_MAX_X) ? {S{1'b1}} : thr_whole[S-1:0];
  assign ind_on    = now < indicator_off_time;

  always_comb begin
    out_word = '0;
    out_word[0] = ind_on;
    out_word[1] = beat;
    out_word[2] = first;
    out_word[3 +: BPM_W] = bpm;
    out_word[3 + BPM_W +: S + 1] = sm_whole[S:0];
    out_word[4 + BPM_W + S +: S] = thr_out;
  end

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      m_tvalid           <= 1'b0;
      baseline_alpha     <= BASELINE_ALPHA_RESET;
      smoothing_alpha    <= SMOOTHING_ALPHA_RESET;
      envelope_decay     <= ENVELOPE_DECAY_RESET;
      threshold_fraction <= THRESHOLD_FRAC_RESET;
      amplitude_floor    <= AMP_FLOOR_RESET;
      refractory_time    <= REFRACTORY_RESET;
      flash_time         <= FLASH_RESET;
      invert_polarity    <= 1'b0;
      baseline_level     <= '0;
      seeded_flag        <= 1'b0;
      smoothed_level     <= '0;
      peak_envelope      <= ENV_RESET;
      previously_above   <= 1'b0;
      last_beat_time     <= '0;
      beat_seen          <= 1'b0;
      indicator_off_time <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_BASELINE_ALPHA:  baseline_alpha     <= cfg_data[WEIGHT_W-1:0];
          REG_SMOOTHING_ALPHA: smoothing_alpha    <= cfg_data[WEIGHT_W-1:0];
          REG_ENVELOPE_DECAY:  envelope_decay     <= cfg_data[WEIGHT_W-1:0];
          REG_THRESHOLD_FRAC:  threshold_fraction <= cfg_data[WEIGHT_W-1:0];
          REG_AMP_FLOOR:       amplitude_floor    <= cfg_data[FLOOR_W-1:0];
          REG_REFRACTORY:      refractory_time    <= cfg_data[DUR_W-1:0];
          REG_FLASH:           flash_time         <= cfg_data[DUR_W-1:0];
          REG_INVERT:          invert_polarity    <= cfg_data[0];
        endcase
      end

      if (m_tvalid && m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            raw <= in_raw;
            now <= in_time;
            if (!seeded_flag) begin
              baseline_level <= in_raw_fx;
              seeded_flag    <= 1'b1;
            end
            state <= ST_BASE_MUL;
          end
        end
        ST_BASE_MUL: begin
          prod  <= mul_prod;
          state <= ST_BASE_UPD;
        end
        ST_BASE_UPD: begin
          baseline_level <= base_new;
          state          <= ST_SMO_MUL;
        end
        ST_SMO_MUL: begin
          prod  <= mul_prod;
          state <= ST_SMO_UPD;
        end
        ST_SMO_UPD: begin
          smoothed_level <= smo_new;
          state          <= ST_THR_MUL;
        end
        ST_THR_MUL: begin
          prod  <= mul_prod;
          state <= ST_ENV_MUL;
        end
        ST_ENV_MUL: begin
          thr   <= prod_shift[THR_W-1:0];
          prod  <= mul_prod;
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          beat             <= beat_now;
          first            <= beat_now && !beat_seen;
          bpm              <= '0;
          previously_above <= above;
          peak_envelope    <= env_new;
          state            <= ST_DONE;
          if (beat_now) begin
            beat_seen          <= 1'b1;
            last_beat_time     <= now;
            indicator_off_time <= off_time;
            if (beat_seen) begin
              priority if (interval <= T'(RATE_SAT_LIMIT)) begin
                bpm <= BPM_MAX;
              end else if (|interval[T-1:RATE_NUM_W]) begin
                bpm <= '0;
              end else begin
                rem     <= RATE_NUMER;
                divr    <= {interval[RATE_NUM_W-1:0], {(BPM_W-1){1'b0}}};
                div_cnt <= '0;
                state   <= ST_DIV;
              end
            end
          end
        end
        ST_DIV: begin
          if (div_ge) begin
            rem <= rem - divr[RATE_NUM_W-1:0];
          end
          bpm     <= {bpm[BPM_W-2:0], div_ge};
          divr    <= divr >> 1;
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == CNT_W'(BPM_W - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= out_word;
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `APBD_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
  `APBD_ASSERT_IMPL(a_first_is_beat, m_tvalid && m_tdata[2], m_tdata[1])
  `APBD_ASSERT_IMPL(a_rate_on_later_beat, m_tvalid && (m_tdata[3 +: BPM_W] != '0), m_tdata[1] && !m_tdata[2])
  `APBD_ASSERT_IMPL(a_div_count_range, state == ST_DIV, div_cnt <= CNT_W'(BPM_W - 1))

endmodule

// File: tb/adaptive_pulse_beat_detector_core_tb.sv
`timescale 1ns / 100ps

module adaptive_pulse_beat_detector_core_tb;
  import apbd_pkg::*;

  localparam int     FRAC        = 16;
  localparam longint LEVEL_TOP   = 64'd268435455;
  localparam longint TIME_TOP    = 64'hFFFF_FFFF_FFFF;
  localparam int     QUIET_LIMIT = 3000;

  typedef struct {
    logic [11:0] level;
    logic [47:0] stamp;
  } sample_t;

  typedef struct {
    logic               led_on;
    logic               beat;
    logic               is_first;
    logic [9:0]         bpm;
    logic signed [12:0] level;
    logic [11:0]        thresh;
  } beat_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [63:0]           s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [39:0]           m_tdata;
  logic                  cfg_we = 1'b0;
  cfg_index_t            cfg_index = REG_BASELINE_ALPHA;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  adaptive_pulse_beat_detector_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Register copies kept by the predictor.
  longint base_w        = BASELINE_ALPHA_RESET;
  longint smooth_w      = SMOOTHING_ALPHA_RESET;
  longint decay_w       = ENVELOPE_DECAY_RESET;
  longint thresh_w      = THRESHOLD_FRAC_RESET;
  longint floor_counts  = AMP_FLOOR_RESET;
  longint refractory_us = REFRACTORY_RESET;
  longint flash_us      = FLASH_RESET;
  longint invert_on     = 0;

  // Detector state.
  longint baseline_fx = 0;
  logic   seeded      = 1'b0;
  longint smooth_fx   = 0;
  longint envelope_fx = longint'(AMP_FLOOR_RESET) << FRAC;
  logic   prior_above = 1'b0;
  longint prior_beat_us = 0;
  logic   beat_seen   = 1'b0;
  longint led_off_us  = 0;

  sample_t      pending_samples[$];
  beat_result_t expected_beats[$];

  int          sender_gap_max = 6;
  int          rx_stall_max   = 6;
  int          results_seen   = 0;
  int          mismatches     = 0;
  int          beats          = 0;
  int          first_beats    = 0;
  int          capped_rates   = 0;
  int          settings       = 1;
  int unsigned tx_hold        = 0;
  int unsigned rx_wait        = 0;
  int          quiet_cycles   = 0;
  longint      clock_us       = 0;

  function automatic longint clip(input longint x, input longint lo, input longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  function automatic beat_result_t predict_beat(input logic [11:0] level,
                                                input logic [47:0] stamp);
    beat_result_t r;
    longint raw_fx, floor_fx, ac, thr, env, now, span, rate;
    logic above;
    now      = longint'(stamp);
    raw_fx   = longint'(level) << FRAC;
    floor_fx = floor_counts << FRAC;
    r        = '{default: '0};
    if (!seeded) begin
      baseline_fx = raw_fx;
      seeded      = 1'b1;
    end
    baseline_fx = clip(baseline_fx + ((base_w * (raw_fx - baseline_fx)) >>> FRAC),
                       0, LEVEL_TOP);
    ac = raw_fx - baseline_fx;
    if (invert_on != 0) begin
      ac = -ac;
    end
    smooth_fx = clip(smooth_fx + ((smooth_w * (ac - smooth_fx)) >>> FRAC),
                     -LEVEL_TOP - 1, LEVEL_TOP);
    thr   = (envelope_fx * thresh_w) >>> FRAC;
    above = (smooth_fx > thr) && (smooth_fx > floor_fx);
    span  = now - prior_beat_us;
    if (above && !prior_above && now > prior_beat_us && span > refractory_us) begin
      r.beat = 1'b1;
      beats++;
      if (beat_seen) begin
        rate = longint'(RATE_NUMER) / span;
        if (rate > longint'(BPM_MAX)) begin
          rate = longint'(BPM_MAX);
          capped_rates++;
        end
        r.bpm = 10'(rate);
      end else begin
        r.is_first = 1'b1;
        first_beats++;
      end
      beat_seen     = 1'b1;
      prior_beat_us = now;
      led_off_us    = (TIME_TOP - now < flash_us) ? TIME_TOP : now + flash_us;
    end
    prior_above = above;
    env = (envelope_fx * decay_w) >>> FRAC;
    if (smooth_fx > env) begin
      env = smooth_fx;
    end
    if (env < floor_fx) begin
      env = floor_fx;
    end
    envelope_fx = clip(env, 0, LEVEL_TOP);
    r.led_on = now < led_off_us;
    r.level  = 13'((smooth_fx >= 0) ? (smooth_fx >>> FRAC) : -((-smooth_fx) >>> FRAC));
    r.thresh = 12'(((thr >>> FRAC) > 4095) ? 4095 : (thr >>> FRAC));
    return r;
  endfunction

  function automatic void check_field(input string name, input longint want,
                                      input longint got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : drive_samples
    sample_t next_sample;
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_hold  <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_beats.push_back(predict_beat(s_tdata[11:0], s_tdata[59:12]));
      end
      if (!s_tvalid || s_tready) begin
        if (tx_hold != 0) begin
          tx_hold  <= tx_hold - 1;
          s_tvalid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          next_sample = pending_samples.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {4'd0, next_sample.stamp, next_sample.level};
          tx_hold  <= $urandom_range(0, sender_gap_max);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : collect_results
    beat_result_t want;
    int unsigned w;
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait  <= 0;
    end else if (m_tvalid && m_tready) begin
      if (expected_beats.size() == 0) begin
        $error("result beat with no sample outstanding: %h", m_tdata);
        mismatches++;
      end else begin
        want = expected_beats.pop_front();
        check_field("indicator_on", want.led_on, m_tdata[0]);
        check_field("beat_detected", want.beat, m_tdata[1]);
        check_field("first_beat", want.is_first, m_tdata[2]);
        check_field("beats_per_minute", want.bpm, m_tdata[12:3]);
        check_field("smoothed_signal", want.level, $signed(m_tdata[25:13]));
        check_field("beat_threshold", want.thresh, m_tdata[37:26]);
      end
      // Every so often the sink backs off long enough for the core to fill up.
      w = (results_seen % 150 == 60) ? 250 : $urandom_range(0, rx_stall_max);
      results_seen++;
      rx_wait  <= w;
      m_tready <= (w == 0);
    end else if (rx_wait != 0) begin
      rx_wait  <= rx_wait - 1;
      m_tready <= (rx_wait == 1);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_sample(input longint level, input longint stamp);
    sample_t s;
    s.level = 12'(clip(level, 0, 4095));
    s.stamp = 48'(clip(stamp, 0, TIME_TOP));
    pending_samples.push_back(s);
  endtask

  // Sharp upstroke over the first quarter of the period, slow fall after it,
  // with a little jitter and the occasional wild reading.
  task automatic pulse_train(input int n, input int base, input int amp,
                             input int period, input int step_us);
    int i, ph, v;
    for (i = 0; i < n; i++) begin
      ph = i % period;
      if (ph * 4 < period) begin
        v = base + amp * 4 * ph / period;
      end else begin
        v = base + amp * 4 * (period - ph) / (3 * period);
      end
      v = v + $urandom_range(0, 8) - 4;
      if ($urandom_range(0, 15) == 0) begin
        v = $urandom_range(0, 4095);
      end
      clock_us = clock_us + step_us + $urandom_range(0, step_us / 8);
      add_sample(v, clock_us);
    end
  endtask

  task automatic drain();
    do begin
      @(negedge clk);
    end while (pending_samples.size() != 0 || s_tvalid || expected_beats.size() != 0);
    repeat (25) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input longint value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_BASELINE_ALPHA:  base_w        = value & 64'hFFFF;
      REG_SMOOTHING_ALPHA: smooth_w      = value & 64'hFFFF;
      REG_ENVELOPE_DECAY:  decay_w       = value & 64'hFFFF;
      REG_THRESHOLD_FRAC:  thresh_w      = value & 64'hFFFF;
      REG_AMP_FLOOR:       floor_counts  = value & 64'hFFF;
      REG_REFRACTORY:      refractory_us = value & 64'hFF_FFFF;
      REG_FLASH:           flash_us      = value & 64'hFF_FFFF;
      REG_INVERT:          invert_on     = value & 64'h1;
      default: ;
    endcase
  endtask

  task automatic program_regs(input longint ba, input longint sa, input longint ed,
                              input longint tf, input longint af, input longint rt,
                              input longint ft, input longint inv);
    drain();
    write_reg(REG_BASELINE_ALPHA, ba);
    write_reg(REG_SMOOTHING_ALPHA, sa);
    write_reg(REG_ENVELOPE_DECAY, ed);
    write_reg(REG_THRESHOLD_FRAC, tf);
    write_reg(REG_AMP_FLOOR, af);
    write_reg(REG_REFRACTORY, rt);
    write_reg(REG_FLASH, ft);
    write_reg(REG_INVERT, inv);
    settings++;
    @(negedge clk);
  endtask

  initial begin
    int p, inv, amp;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Seed sample at time zero, full-scale swings, then two pulses far enough
    // apart to give a first beat and a rate, a pair of samples stamped before
    // the last beat, and a late pulse.
    add_sample(2048, 0);
    add_sample(0, 100000);
    add_sample(4095, 200000);
    add_sample(2048, 300000);
    add_sample(3500, 350000);
    add_sample(3500, 400000);
    add_sample(2048, 450000);
    add_sample(2048, 500000);
    add_sample(2048, 550000);
    add_sample(3500, 700000);
    add_sample(3600, 720000);
    add_sample(2048, 800000);
    add_sample(2048, 100);
    add_sample(4095, 200);
    add_sample(2048, 900000);
    add_sample(1500, 1000000);
    add_sample(4000, 1100000);
    add_sample(4095, 1150000);
    add_sample(2048, 1300000);
    add_sample(0, 1400000);
    clock_us = 2000000;
    drain();

    // Default registers, realistic rate.
    pulse_train(100, 2000, 900, 40, 20000);

    // Every register at its top value, no idling on either side.
    sender_gap_max = 0;
    rx_stall_max   = 0;
    program_regs(65535, 65535, 65535, 65535, 4095, 16777215, 16777215, 1);
    pulse_train(50, 1500, -1200, 20, 30000);

    // Every register at zero.
    sender_gap_max = 6;
    rx_stall_max   = 6;
    program_regs(0, 0, 0, 0, 0, 0, 0, 0);
    pulse_train(30, 2500, 1000, 10, 10000);

    // Short intervals with no refractory time drive the rate into saturation.
    rx_stall_max = 0;
    program_regs(2000, 40000, 60000, 32768, 10, 0, 500, 0);
    pulse_train(80, 2000, 1500, 6, 1000);

    for (p = 0; p < 4; p++) begin
      sender_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 6;
      rx_stall_max   = ($urandom_range(0, 2) == 0) ? 0 : 6;
      inv = $urandom_range(0, 1);
      program_regs($urandom_range(0, 8000), $urandom_range(4000, 65535),
                   $urandom_range(55000, 65535), $urandom_range(16384, 52000),
                   $urandom_range(0, 200), $urandom_range(0, 600000),
                   $urandom_range(0, 400000), inv);
      amp = $urandom_range(200, 1000);
      if ((inv == 1) != ($urandom_range(0, 3) == 0)) begin
        amp = -amp;
      end
      pulse_train(55, $urandom_range(800, 3000), amp, $urandom_range(8, 50),
                  $urandom_range(5000, 40000));
    end

    // Arbitrary timestamps across the whole range, then a pulse train that runs
    // into the largest time value so that the indicator deadline saturates.
    sender_gap_max = 6;
    rx_stall_max   = 6;
    program_regs(655, 19661, 62915, 32768, 25, 1000, 16777215, 0);
    for (p = 0; p < 20; p++) begin
      add_sample($urandom_range(0, 4095), longint'({$urandom, $urandom}) & TIME_TOP);
    end
    clock_us = TIME_TOP - 3400000;
    pulse_train(60, 2000, 1200, 12, 50000);
    add_sample(4095, TIME_TOP);
    drain();

    $display("tb: %0d samples checked, %0d beats (%0d first, %0d at the rate ceiling)",
             results_seen, beats, first_beats, capped_rates);
    $display("tb: %0d register settings, %0d mismatches", settings, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
